@@ sv/pspq_pkg.sv @@
// ----------------------------------------------------------------------------
// pspq_pkg - shared constants and types for the prime sieve query block
// Table geometry, prime list bound and the sequencer state encoding.
// ----------------------------------------------------------------------------
package pspq_pkg;

  localparam int TableSize       = 65536;
  localparam int SmallPrimeBound = 50000;
  localparam int PrimeListDepth  = 8192;

  localparam int TableAw = $clog2(TableSize);
  localparam int ListAw  = $clog2(PrimeListDepth);
  localparam int CountW  = ListAw + 1;

  localparam logic [15:0] LimitReset = 16'hFFFF;
  localparam logic        OpBuild    = 1'b0;
  localparam logic        OpQuery    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OUTER_RD,
    ST_OUTER_CHK,
    ST_INNER_RD,
    ST_INNER_CHK,
    ST_Q_TBL,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_DIV,
    ST_Q_REM,
    ST_DONE
  } state_t;

endpackage

@@ sv/prime_sieve_primality_query.sv @@
// ----------------------------------------------------------------------------
// prime_sieve_primality_query - sieve table build and primality query
// Builds a smallest-prime-factor table and answers primality requests.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): opcode 0 builds the table, opcode 1 queries
// number. Each request gives one result on the output channel: is_prime,
// smallest_factor and table_ready.
// A query at or below table_limit is answered from one factor table read.
// A query above it walks the prime list, trying each listed prime with the
// 31-step bit-serial remainder unit. A build sweeps all 65536 table entries
// (one a cycle), then runs the sieve, which reads each table entry it visits
// and marks it only if no smaller prime has claimed it.
// One request is in work at a time; a new request is taken as soon as the
// sequencer is idle, even while the previous result waits in the output
// register. If the receiver stalls, the finished result waits in the
// sequencer until the output register is free.
// Reset: a clearing pass over the 65536 entries zeroes the factor table; no
// request is accepted during it. APB writes are taken at any time.
// ----------------------------------------------------------------------------
module prime_sieve_primality_query
  import pspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [30:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_prime,
  output logic [30:0] smallest_factor,
  output logic        table_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] ft_mem [TableSize];
  logic [15:0] sp_mem [PrimeListDepth];

  state_t state, state_next;

  logic [15:0]        table_limit;
  logic               built_flag, built_flag_next;
  logic [CountW-1:0]  prime_count, prime_count_next;
  logic [TableAw:0]   idx_i, idx_i_next;
  logic [TableAw:0]   idx_j, idx_j_next;
  logic [TableAw-1:0] clr_addr, clr_addr_next;
  logic               clr_build, clr_build_next;
  logic [CountW-1:0]  idx_k, idx_k_next;
  logic [30:0]        q_num, q_num_next;
  logic [15:0]        q_div, q_div_next;
  logic [15:0]        rem, rem_next;
  logic [4:0]         bit_cnt, bit_cnt_next;
  logic               res_prime, res_prime_next;
  logic [30:0]        res_factor, res_factor_next;

  logic               ft_we;
  logic [TableAw-1:0] ft_waddr, ft_raddr;
  logic [15:0]        ft_wdata, ft_rdata;
  logic               sp_we;
  logic [ListAw-1:0]  sp_waddr, sp_raddr;
  logic [15:0]        sp_wdata, sp_rdata;

  logic               accept, out_free;
  logic [TableAw:0]   lim_ext;
  logic [31:0]        q_sq;
  logic [16:0]        rem_sh;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {16'b0, table_limit} : 32'b0;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign lim_ext   = {1'b0, table_limit};
  assign q_sq      = {16'b0, sp_rdata} * {16'b0, sp_rdata};
  assign rem_sh    = {rem, q_num[bit_cnt]};

  // APB register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= LimitReset;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      table_limit <= pwdata[15:0];
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (ft_we) ft_mem[ft_waddr] <= ft_wdata;
    ft_rdata <= ft_mem[ft_raddr];
  end

  always_ff @(posedge clk) begin
    if (sp_we) sp_mem[sp_waddr] <= sp_wdata;
    sp_rdata <= sp_mem[sp_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == TableAw'(TableSize - 1)) begin
          state_next = clr_build ? ST_OUTER_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OpBuild)        state_next = ST_CLEAR;
          else if (number < 31'd2)      state_next = ST_DONE;
          else if (number <= 31'(table_limit)) state_next = ST_Q_TBL;
          else                          state_next = ST_Q_RD;
        end
      end
      ST_OUTER_RD:  state_next = (idx_i > lim_ext) ? ST_DONE : ST_OUTER_CHK;
      ST_OUTER_CHK: state_next = (ft_rdata == 16'd0) ? ST_INNER_RD : ST_OUTER_RD;
      ST_INNER_RD:  state_next = (idx_j > lim_ext) ? ST_OUTER_RD : ST_INNER_CHK;
      ST_INNER_CHK: state_next = ST_INNER_RD;
      ST_Q_TBL:     state_next = ST_DONE;
      ST_Q_RD:      state_next = (idx_k >= prime_count) ? ST_DONE : ST_Q_CHK;
      ST_Q_CHK: begin
        if (sp_rdata == 16'd0 || q_sq > {1'b0, q_num}) state_next = ST_DONE;
        else                                          state_next = ST_Q_DIV;
      end
      ST_Q_DIV:     state_next = (bit_cnt == 5'd0) ? ST_Q_REM : ST_Q_DIV;
      ST_Q_REM:     state_next = (rem == 16'd0) ? ST_DONE : ST_Q_RD;
      ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    built_flag_next  = built_flag;
    prime_count_next = prime_count;
    idx_i_next       = idx_i;
    idx_j_next       = idx_j;
    clr_addr_next    = clr_addr;
    clr_build_next   = clr_build;
    idx_k_next       = idx_k;
    q_num_next       = q_num;
    q_div_next       = q_div;
    rem_next         = rem;
    bit_cnt_next     = bit_cnt;
    res_prime_next   = res_prime;
    res_factor_next  = res_factor;
    ft_we    = 1'b0;
    ft_waddr = clr_addr;
    ft_wdata = 16'd0;
    ft_raddr = idx_i[TableAw-1:0];
    sp_we    = 1'b0;
    sp_waddr = prime_count[ListAw-1:0];
    sp_wdata = idx_i[15:0];
    sp_raddr = idx_k[ListAw-1:0];
    case (state)
      ST_CLEAR: begin
        ft_we         = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        idx_i_next    = (TableAw + 1)'(2);
      end
      ST_IDLE: begin
        ft_raddr        = number[TableAw-1:0];
        q_num_next      = number;
        idx_k_next      = '0;
        res_prime_next  = 1'b0;
        res_factor_next = 31'd0;
        if (accept && opcode == OpBuild) begin
          clr_addr_next    = '0;
          clr_build_next   = 1'b1;
          prime_count_next = '0;
        end
      end
      ST_OUTER_RD: begin
        ft_raddr = idx_i[TableAw-1:0];
        if (idx_i > lim_ext) built_flag_next = 1'b1;
      end
      ST_OUTER_CHK: begin
        if (ft_rdata == 16'd0) begin
          idx_j_next = idx_i;
          if (idx_i < (TableAw + 1)'(SmallPrimeBound) &&
              prime_count < CountW'(PrimeListDepth)) begin
            sp_we            = 1'b1;
            prime_count_next = prime_count + 1'b1;
          end
        end else begin
          idx_i_next = idx_i + 1'b1;
        end
      end
      ST_INNER_RD: begin
        ft_raddr = idx_j[TableAw-1:0];
        if (idx_j > lim_ext) idx_i_next = idx_i + 1'b1;
      end
      ST_INNER_CHK: begin
        // mark only numbers no smaller prime has claimed
        ft_waddr   = idx_j[TableAw-1:0];
        ft_wdata   = idx_i[15:0];
        ft_we      = (ft_rdata == 16'd0);
        idx_j_next = idx_j + idx_i;
      end
      ST_Q_TBL: begin
        res_factor_next = {15'b0, ft_rdata};
        res_prime_next  = ({15'b0, ft_rdata} == q_num);
      end
      ST_Q_RD: begin
        sp_raddr = idx_k[ListAw-1:0];
        if (idx_k >= prime_count) begin
          res_prime_next  = 1'b1;
          res_factor_next = q_num;
        end
      end
      ST_Q_CHK: begin
        q_div_next   = sp_rdata;
        rem_next     = 16'd0;
        bit_cnt_next = 5'd30;
        if (sp_rdata == 16'd0 || q_sq > {1'b0, q_num}) begin
          res_prime_next  = 1'b1;
          res_factor_next = q_num;
        end
      end
      ST_Q_DIV: begin
        // one restoring remainder step per cycle, high bit first
        if (rem_sh >= {1'b0, q_div}) rem_next = 16'(rem_sh - {1'b0, q_div});
        else                         rem_next = rem_sh[15:0];
        bit_cnt_next = bit_cnt - 1'b1;
      end
      ST_Q_REM: begin
        if (rem == 16'd0) begin
          res_prime_next  = 1'b0;
          res_factor_next = {15'b0, q_div};
        end else begin
          idx_k_next = idx_k + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      built_flag  <= 1'b0;
      prime_count <= '0;
      clr_addr    <= '0;
      clr_build   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      built_flag  <= built_flag_next;
      prime_count <= prime_count_next;
      clr_addr    <= clr_addr_next;
      clr_build   <= clr_build_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_i      <= idx_i_next;
    idx_j      <= idx_j_next;
    idx_k      <= idx_k_next;
    q_num      <= q_num_next;
    q_div      <= q_div_next;
    rem        <= rem_next;
    bit_cnt    <= bit_cnt_next;
    res_prime  <= res_prime_next;
    res_factor <= res_factor_next;
    if (state == ST_DONE && out_free) begin
      is_prime        <= res_prime;
      smallest_factor <= res_factor;
      table_ready     <= built_flag;
    end
  end

endmodule

@@ tb/tb_sieve_checker.sv @@
// ----------------------------------------------------------------------------
// tb_sieve_checker - answer predictor and scoreboard for the prime sieve
// Watches the request, result and APB channels. Keeps its own sieve table,
// prime list and limit, predicts each answer and compares it in order.
// ----------------------------------------------------------------------------
module tb_sieve_checker
  import pspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [30:0] number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        is_prime,
  input  logic [30:0] smallest_factor,
  input  logic        table_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  localparam logic [2:0] AddrTableLimit = 3'd0;

  typedef struct packed {
    logic        prime;
    logic [30:0] factor;
    logic        ready;
  } answer_t;

  int unsigned spf_table[TableSize];
  int unsigned prime_list[$];
  logic        built;
  logic [15:0] limit_reg;
  answer_t     pending_answers[$];

  function automatic int unsigned eff_limit();
    return (limit_reg > TableSize - 1) ? TableSize - 1 : limit_reg;
  endfunction

  task automatic sieve_build();
    int unsigned lim;
    lim = eff_limit();
    foreach (spf_table[i]) spf_table[i] = 0;
    prime_list.delete();
    for (int unsigned i = 2; i <= lim; i++) begin
      if (spf_table[i] == 0) begin
        for (int unsigned j = i; j <= lim; j += i)
          if (spf_table[j] == 0) spf_table[j] = i;
      end
    end
    for (int unsigned i = 2; i < SmallPrimeBound && i <= lim; i++)
      if (spf_table[i] == i && prime_list.size() < PrimeListDepth)
        prime_list = {prime_list, i};
    built = 1'b1;
  endtask

  function automatic answer_t predict_answer(logic [30:0] n);
    answer_t     a;
    longint      q;
    a = '0;
    a.ready = built;
    if (n < 2) return a;
    if (n <= eff_limit()) begin
      a.factor = 31'(spf_table[n]);
      a.prime  = (spf_table[n] == n);
      return a;
    end
    foreach (prime_list[k]) begin
      q = prime_list[k];
      if (q == 0 || q * q > longint'(n)) break;
      if (longint'(n) % q == 0) begin
        a.factor = 31'(q);
        return a;
      end
    end
    a.prime  = 1'b1;
    a.factor = n;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    answer_t want;
    if (rst) begin
      foreach (spf_table[i]) spf_table[i] = 0;
      limit_reg  = LimitReset;
      built      = 1'b0;
      fail_count = 0;
      prime_list.delete();
      pending_answers.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrTableLimit)
        limit_reg = pwdata[15:0];
      if (in_valid && in_ready) begin
        if (opcode == OpBuild) begin
          sieve_build();
          a = '0;
          a.ready = built;
        end else begin
          a = predict_answer(number);
        end
        pending_answers = {pending_answers, a};
      end
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result prime=%0d factor=%0d ready=%0d",
                   $time, is_prime, smallest_factor, table_ready);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (is_prime !== want.prime) begin
            $display("%0t: is_prime expected %0d actual %0d", $time, want.prime, is_prime);
            fail_count++;
          end
          if (smallest_factor !== want.factor) begin
            $display("%0t: smallest_factor expected %0d actual %0d",
                     $time, want.factor, smallest_factor);
            fail_count++;
          end
          if (table_ready !== want.ready) begin
            $display("%0t: table_ready expected %0d actual %0d",
                     $time, want.ready, table_ready);
            fail_count++;
          end
        end
      end
    end
    pending = pending_answers.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the prime sieve primality block
// Drives builds, queries and limit writes with random idling on both sides;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
  import pspq_pkg::*;
();

  localparam int CycleLimit = 6000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OpQuery;
  logic [30:0] number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_prime;
  logic [30:0] smallest_factor;
  logic        table_ready;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int unsigned limit_cur = LimitReset;
  int          cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prime_sieve_primality_query u_dut (.*);

  tb_sieve_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .opcode, .number, .out_valid, .out_ready,
    .is_prime, .smallest_factor, .table_ready, .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .fail_count, .pending
  );

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [30:0] n);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    number   <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_limit(logic [15:0] lim);
    // hold off until every result is back
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {16'($urandom_range(16'hFFFF)), lim};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_cur = lim;
  endtask

  function automatic logic [30:0] random_number();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 31'($urandom_range(limit_cur));
    if (r < 80) return 31'($urandom_range(20));
    if (r < 88) return 31'($urandom_range(limit_cur + 1, 1 << 20));
    if (r < 95) return 31'($urandom & 32'h7FFF_FFFE);
    return 31'(3 * $urandom_range(715827882));
  endfunction

  task automatic random_queries(int count);
    repeat (count) send_request(OpQuery, random_number());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // table still empty, prime list empty
    send_request(OpQuery, 31'd0);
    send_request(OpQuery, 31'd1);
    send_request(OpQuery, 31'd2);
    send_request(OpQuery, 31'd100);
    send_request(OpQuery, 31'd70000);
    send_request(OpQuery, 31'h7FFF_FFFF);

    write_limit(16'd49999);
    send_request(OpBuild, 31'h7FFF_FFFF);
    send_request(OpQuery, 31'd0);
    send_request(OpQuery, 31'd1);
    send_request(OpQuery, 31'd2);
    send_request(OpQuery, 31'd3);
    send_request(OpQuery, 31'd4);
    send_request(OpQuery, 31'd49997);
    send_request(OpQuery, 31'd49999);
    send_request(OpQuery, 31'd50000);
    send_request(OpQuery, 31'd50021);
    send_request(OpQuery, 31'd1018081);
    send_request(OpQuery, 31'h7FFF_FFFE);
    send_request(OpQuery, 31'd2147483645);

    tx_idle_pct = 38;
    rx_idle_pct = 46;
    random_queries(440);

    // raise the limit over an unbuilt part of the table
    write_limit(16'hFFFF);
    send_request(OpQuery, 31'd60000);
    send_request(OpQuery, 31'd65535);
    tx_idle_pct = 46;
    rx_idle_pct = 38;
    random_queries(440);

    send_request(OpBuild, 31'd0);
    send_request(OpQuery, 31'd65521);
    send_request(OpQuery, 31'd65535);
    write_limit(16'd57000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_queries(440);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ prime_sieve_primality_query.f @@
sv/pspq_pkg.sv
sv/prime_sieve_primality_query.sv
tb/tb_sieve_checker.sv
tb/tb_top.sv
